// ===== rtl/core/oprle_pkg.sv =====
// Shared types and constants for the order-preserving run-length compressor.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package oprle_pkg;

  // Number of bytes held in the open plain block
  localparam int BUF_DEPTH = 7;
  // Most bytes one input transfer can produce
  localparam int MAX_OUT = 8;

  localparam logic [2:0]  FILL_FULL      = 3'd7;
  localparam logic [2:0]  FILL_RUN_SEED  = 3'd3;
  localparam logic [30:0] RUN_MAX        = 31'h7fff_ffff;
  localparam logic [30:0] RUN_START      = 31'd4;

  // Input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last_of_step;
    logic       out_end_of_string;
    logic       run_overflow;
  } out_item_t;

  // One classified step: the bytes it emits, in order, plus step flags
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [2:0]              last_idx;
    logic                    end_flag;
    logic                    ovf;
  } job_t;

  // 32-bit count field, inverted when the following byte sorts higher
  function automatic logic [31:0] count_code(logic [30:0] cnt, logic inv);
    logic [31:0] plain;
    plain = {1'b0, cnt};
    count_code = inv ? ~plain : plain;
  endfunction

endpackage

// ===== rtl/core/oprle_front.sv =====
// Front end: accepts input bytes, tracks block and run state, and builds one
// job of up to eight output bytes per step. Depends on oprle_pkg.
`timescale 1ns / 1ps

module oprle_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  oprle_pkg::in_item_t item,
  output logic               push,
  output oprle_pkg::job_t    job
);

  logic [7:0]  buf_r [0:oprle_pkg::BUF_DEPTH-1];
  logic [2:0]  fill_r, fill_nxt;
  logic        in_run_r, in_run_nxt;
  logic [7:0]  run_char_r, run_char_nxt;
  logic [30:0] run_count_r, run_count_nxt;
  logic        ovf_r, ovf_nxt;

  logic        wr_en;
  logic [2:0]  wr_idx;
  logic [3:0]  n_out;
  logic [31:0] code;
  logic [7:0]  b;
  logic        last;

  assign b    = item.in_byte;
  assign last = item.in_last;

  // Classify the step and assemble its output bytes
  always_comb begin
    fill_nxt      = fill_r;
    in_run_nxt    = in_run_r;
    run_char_nxt  = run_char_r;
    run_count_nxt = run_count_r;
    ovf_nxt       = ovf_r;
    wr_en         = 1'b0;
    wr_idx        = fill_r;
    n_out         = 4'd0;
    code          = '0;
    job           = '0;

    if (in_run_r) begin
      if (b == run_char_r) begin
        // extend the run, saturating at the count limit
        if (run_count_r != oprle_pkg::RUN_MAX) begin
          run_count_nxt = run_count_r + 31'd1;
        end else begin
          ovf_nxt = 1'b1;
        end
        code = oprle_pkg::count_code(run_count_nxt, 1'b0);
        if (last) begin
          n_out = 4'd4;
        end
      end else begin
        // close the run; the new byte opens a plain block
        code       = oprle_pkg::count_code(run_count_r, b > run_char_r);
        in_run_nxt = 1'b0;
        wr_en      = 1'b1;
        wr_idx     = 3'd0;
        fill_nxt   = 3'd1;
        job.bytes[4] = b;
        n_out      = last ? 4'd5 : 4'd4;
      end
      job.bytes[0] = code[31:24];
      job.bytes[1] = code[23:16];
      job.bytes[2] = code[15:8];
      job.bytes[3] = code[7:0];
    end else if (fill_r == oprle_pkg::FILL_FULL) begin
      // full plain block: flush seven held bytes and this one
      for (int k = 0; k < oprle_pkg::BUF_DEPTH; k++) begin
        job.bytes[k] = buf_r[k];
      end
      job.bytes[oprle_pkg::MAX_OUT-1] = b;
      fill_nxt = 3'd0;
      n_out    = 4'd8;
    end else if (fill_r == oprle_pkg::FILL_RUN_SEED && buf_r[0] == b &&
                 buf_r[1] == b && buf_r[2] == b) begin
      // four equal bytes open a run block
      for (int k = 0; k < 4; k++) begin
        job.bytes[k] = b;
      end
      code          = oprle_pkg::count_code(oprle_pkg::RUN_START, 1'b0);
      job.bytes[4]  = code[31:24];
      job.bytes[5]  = code[23:16];
      job.bytes[6]  = code[15:8];
      job.bytes[7]  = code[7:0];
      fill_nxt      = 3'd0;
      in_run_nxt    = 1'b1;
      run_char_nxt  = b;
      run_count_nxt = oprle_pkg::RUN_START;
      n_out         = last ? 4'd8 : 4'd4;
    end else begin
      // hold the byte; flush the partial block at end of string
      wr_en    = 1'b1;
      fill_nxt = fill_r + 3'd1;
      for (int k = 0; k < oprle_pkg::BUF_DEPTH; k++) begin
        if (3'(k) < fill_r) begin
          job.bytes[k] = buf_r[k];
        end else if (3'(k) == fill_r) begin
          job.bytes[k] = b;
        end
      end
      if (last) begin
        n_out = {1'b0, fill_r} + 4'd1;
      end
    end

    job.ovf      = ovf_nxt;
    job.end_flag = last;
    job.last_idx = 3'(n_out - 4'd1);

    // end of string returns all state to reset values
    if (last) begin
      fill_nxt      = 3'd0;
      in_run_nxt    = 1'b0;
      run_char_nxt  = 8'd0;
      run_count_nxt = 31'd0;
      ovf_nxt       = 1'b0;
    end
  end

  assign push = take && (n_out != 4'd0);

  // Advance state on each accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 3'd0;
      in_run_r    <= 1'b0;
      run_char_r  <= 8'd0;
      run_count_r <= 31'd0;
      ovf_r       <= 1'b0;
    end else if (take) begin
      fill_r      <= fill_nxt;
      in_run_r    <= in_run_nxt;
      run_char_r  <= run_char_nxt;
      run_count_r <= run_count_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // Block buffer write
  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      buf_r[wr_idx] <= b;
    end
  end

endmodule

// ===== rtl/core/oprle_queue.sv =====
// Job queue between front and back ends; a small circular buffer.
// Depends on oprle_pkg for the job type.
`timescale 1ns / 1ps

module oprle_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  oprle_pkg::job_t push_data,
  input  logic            pop,
  output logic            not_empty,
  output logic            full,
  output oprle_pkg::job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  oprle_pkg::job_t   slot_r [0:DEPTH-1];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign head      = slot_r[rd_ptr_r];

  // Wrap pointers, track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold job payloads
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/oprle_back.sv =====
// Back end: takes jobs from the queue and emits their bytes one per transfer.
// Depends on oprle_pkg.
`timescale 1ns / 1ps

module oprle_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  oprle_pkg::job_t     q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output oprle_pkg::out_item_t out_data
);

  logic            busy_r, busy_nxt;
  oprle_pkg::job_t job_r;
  logic [2:0]      idx_r, idx_nxt;
  logic            fire, at_end, done;

  assign at_end = (idx_r == job_r.last_idx);
  assign fire   = busy_r && !out_stall;
  assign done   = fire && at_end;
  assign q_pop  = q_valid && (!busy_r || done);

  // Step through the current job, load the next one as it ends
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (fire) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
  end

  // Present the selected byte and its flags
  assign out_valid                  = busy_r;
  assign out_data.out_byte          = job_r.bytes[idx_r];
  assign out_data.out_last_of_step  = at_end;
  assign out_data.out_end_of_string = at_end && job_r.end_flag;
  assign out_data.run_overflow      = job_r.ovf;

endmodule

// ===== rtl/core/order_preserving_rle_compressor_core.sv =====
// Order-preserving run-length compressor, top level.
// Instantiates oprle_front, oprle_queue and oprle_back; uses oprle_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one byte of the
//   string per transfer, with in_last on the final byte. Output channel
//   (out_valid / out_stall / out_data) carries compressed bytes, with flags
//   for the last byte of each input step, the end of the string, and run
//   count saturation.
//   Each input byte is classified in the cycle it is taken; a step that
//   emits bytes becomes one job (1 to 8 bytes) in the job queue. With the
//   queue and back end idle, the job is written into the queue, then loaded
//   into the back end, which raises out_valid. The back end emits one byte
//   per cycle while out_stall is low, so an input byte is taken every
//   cycle while the queue has room; sustained rate is set by the output,
//   with bursts of up to eight bytes per step absorbed by QUEUE_DEPTH jobs.
//   in_stall is high while the queue is full. A stalled output holds its
//   byte; input keeps being taken until the queue fills.
//   Synchronous reset clears block and run state, the queue and the output.
`timescale 1ns / 1ps

module order_preserving_rle_compressor_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  oprle_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output oprle_pkg::out_item_t out_data
);

  logic            take;
  logic            push;
  oprle_pkg::job_t job;
  logic            q_valid, q_full, q_pop;
  oprle_pkg::job_t q_head;

  // Accept input while the queue has room
  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  oprle_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_data),
    .push  (push),
    .job   (job)
  );

  oprle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (job),
    .pop       (q_pop),
    .not_empty (q_valid),
    .full      (q_full),
    .head      (q_head)
  );

  oprle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // End of string only on the final byte of a step
  a_end_is_step_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_end_of_string |-> out_data.out_last_of_step)
    else $error("end of string flagged mid-step");

  // Never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job queue popped while empty");

  // Never push into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("job queue pushed while full");

  // A job's bytes go out without a gap
  a_job_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.out_last_of_step |=> out_valid)
    else $error("output dropped in the middle of a job");

endmodule
